// ===== rtl/source_token_scanner_defines.svh =====
// ----------------------------------------------------------------------------
// source_token_scanner_defines
// assertion macros shared by the scanner modules
// ----------------------------------------------------------------------------
`ifndef SOURCE_TOKEN_SCANNER_DEFINES_SVH
`define SOURCE_TOKEN_SCANNER_DEFINES_SVH

// same-cycle implication, checked out of reset
`define STSC_ASSERT_NOW(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("stsc same-cycle check failed");

// next-cycle implication, checked out of reset
`define STSC_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("stsc next-cycle check failed");

`endif

// ===== rtl/stsc_pkg.sv =====
// ----------------------------------------------------------------------------
// stsc_pkg
// shared types, constants and lookup functions of the token scanner
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package stsc_pkg;

    localparam int POS_BITS_DEF   = 16;
    localparam int BRACE_BITS_DEF = 8;

    // token kinds
    localparam logic [3:0] KIND_TEXT   = 4'd0;
    localparam logic [3:0] KIND_CONST  = 4'd1;
    localparam logic [3:0] KIND_IDENT  = 4'd2;
    localparam logic [3:0] KIND_KEYW   = 4'd3;
    localparam logic [3:0] KIND_TYPE   = 4'd4;
    localparam logic [3:0] KIND_OPER   = 4'd5;
    localparam logic [3:0] KIND_STRING = 4'd6;
    localparam logic [3:0] KIND_NSTART = 4'd7;
    localparam logic [3:0] KIND_NATIVE = 4'd8;
    localparam logic [3:0] KIND_END    = 4'd9;
    localparam logic [3:0] KIND_ERROR  = 4'd10;

    // error codes
    localparam logic [1:0] ERR_NONE    = 2'd0;
    localparam logic [1:0] ERR_LETTER  = 2'd1;
    localparam logic [1:0] ERR_STRING  = 2'd2;
    localparam logic [1:0] ERR_UNKNOWN = 2'd3;

    // operator indexes with special handling
    localparam logic [5:0] OP_LINE_CMT  = 6'd43;
    localparam logic [5:0] OP_BLOCK_CMT = 6'd44;
    localparam logic [5:0] CODE_NATIVE  = 6'd10;

    // bytes with special meaning
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_ZERO   = 8'h30;

    typedef struct packed {
        logic [3:0]  kind;
        logic [5:0]  code;
        logic [7:0]  text_byte;
        logic [63:0] number_value;
        logic [15:0] token_row;
        logic [15:0] token_col;
        logic [1:0]  error_code;
    } t_rec;

    // one queue entry: one or two records from one item
    typedef struct packed {
        logic two;
        t_rec rec0;
        t_rec rec1;
    } t_entry;

    typedef struct packed {
        logic       hit;
        logic [5:0] idx;
    } t_op_res;

    typedef struct packed {
        logic [3:0] kind;
        logic [5:0] code;
    } t_word_cls;

    function automatic t_rec mk_rec(logic [3:0] kind, logic [5:0] code, logic [7:0] b,
                                    logic [63:0] val, logic [15:0] row, logic [15:0] col,
                                    logic [1:0] err);
        t_rec r;
        r.kind = kind; r.code = code; r.text_byte = b; r.number_value = val;
        r.token_row = row; r.token_col = col; r.error_code = err;
        return r;
    endfunction

    function automatic logic is_sp(logic [7:0] c);
        return (c == 8'h20) || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic is_dig(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_alf(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    // operator made of one byte
    function automatic t_op_res op_single(logic [7:0] c);
        t_op_res r;
        r.hit = 1'b1;
        case (c)
            ":":     r.idx = 6'd0;
            ";":     r.idx = 6'd1;
            "+":     r.idx = 6'd2;
            "-":     r.idx = 6'd3;
            "*":     r.idx = 6'd4;
            "/":     r.idx = 6'd5;
            "%":     r.idx = 6'd6;
            "&":     r.idx = 6'd11;
            "|":     r.idx = 6'd13;
            "!":     r.idx = 6'd14;
            "~":     r.idx = 6'd15;
            "^":     r.idx = 6'd16;
            "(":     r.idx = 6'd17;
            ")":     r.idx = 6'd18;
            "[":     r.idx = 6'd19;
            "]":     r.idx = 6'd20;
            "=":     r.idx = 6'd22;
            "<":     r.idx = 6'd23;
            ">":     r.idx = 6'd24;
            8'h22:   r.idx = 6'd38;
            8'h27:   r.idx = 6'd39;
            ".":     r.idx = 6'd40;
            ",":     r.idx = 6'd41;
            "?":     r.idx = 6'd42;
            "{":     r.idx = 6'd45;
            "}":     r.idx = 6'd46;
            default: begin
                r.hit = 1'b0; r.idx = 6'd0;
            end
        endcase
        return r;
    endfunction

    // longer operator formed by appending one byte
    function automatic t_op_res op_extend(logic [5:0] base, logic [7:0] c);
        t_op_res r;
        r.hit = 1'b1; r.idx = 6'd0;
        case (base)
            6'd2:  if (c == "=") r.idx = 6'd28; else r.hit = 1'b0;
            6'd3:  if (c == "=") r.idx = 6'd29; else r.hit = 1'b0;
            6'd4:  if (c == "*") r.idx = 6'd7;
                   else if (c == "=") r.idx = 6'd30; else r.hit = 1'b0;
            6'd5:  if (c == "=") r.idx = 6'd31;
                   else if (c == "/") r.idx = OP_LINE_CMT;
                   else if (c == "*") r.idx = OP_BLOCK_CMT; else r.hit = 1'b0;
            6'd7:  if (c == "=") r.idx = 6'd32; else r.hit = 1'b0;
            6'd8:  if (c == "=") r.idx = 6'd33; else r.hit = 1'b0;
            6'd9:  if (c == "=") r.idx = 6'd34; else r.hit = 1'b0;
            6'd11: if (c == "&") r.idx = 6'd10;
                   else if (c == "=") r.idx = 6'd36; else r.hit = 1'b0;
            6'd13: if (c == "|") r.idx = 6'd12;
                   else if (c == "=") r.idx = 6'd35; else r.hit = 1'b0;
            6'd14: if (c == "=") r.idx = 6'd25; else r.hit = 1'b0;
            6'd16: if (c == "=") r.idx = 6'd37; else r.hit = 1'b0;
            6'd22: if (c == "=") r.idx = 6'd21; else r.hit = 1'b0;
            6'd23: if (c == "<") r.idx = 6'd8;
                   else if (c == "=") r.idx = 6'd26; else r.hit = 1'b0;
            6'd24: if (c == ">") r.idx = 6'd9;
                   else if (c == "=") r.idx = 6'd27; else r.hit = 1'b0;
            default: r.hit = 1'b0;
        endcase
        return r;
    endfunction

    // buffer holds the word with its first byte lowest
    function automatic logic word_is(logic [63:0] b, logic [3:0] len, logic [63:0] s, int n);
        logic [63:0] r;
        r = '0;
        for (int k = 0; k < 8; k++) begin
            if (k < n) r[8*k +: 8] = s[8*(n-1-k) +: 8];
        end
        return (b == r) && (len == 4'(n));
    endfunction

    // keyword, typename or plain identifier
    function automatic t_word_cls word_class(logic [63:0] b, logic [3:0] len);
        t_word_cls r;
        r.kind = KIND_IDENT; r.code = 6'd0;
        if      (word_is(b, len, "let", 3))      begin r.kind = KIND_KEYW; r.code = 6'd0; end
        else if (word_is(b, len, "as", 2))       begin r.kind = KIND_KEYW; r.code = 6'd1; end
        else if (word_is(b, len, "class", 5))    begin r.kind = KIND_KEYW; r.code = 6'd2; end
        else if (word_is(b, len, "struct", 6))   begin r.kind = KIND_KEYW; r.code = 6'd3; end
        else if (word_is(b, len, "if", 2))       begin r.kind = KIND_KEYW; r.code = 6'd4; end
        else if (word_is(b, len, "else", 4))     begin r.kind = KIND_KEYW; r.code = 6'd5; end
        else if (word_is(b, len, "for", 3))      begin r.kind = KIND_KEYW; r.code = 6'd6; end
        else if (word_is(b, len, "while", 5))    begin r.kind = KIND_KEYW; r.code = 6'd7; end
        else if (word_is(b, len, "return", 6))   begin r.kind = KIND_KEYW; r.code = 6'd8; end
        else if (word_is(b, len, "continue", 8)) begin r.kind = KIND_KEYW; r.code = 6'd9; end
        else if (word_is(b, len, "void", 4))     begin r.kind = KIND_TYPE; r.code = 6'd0; end
        else if (word_is(b, len, "string", 6))   begin r.kind = KIND_TYPE; r.code = 6'd1; end
        else if (word_is(b, len, "object", 6))   begin r.kind = KIND_TYPE; r.code = 6'd2; end
        else if (word_is(b, len, "list", 4))     begin r.kind = KIND_TYPE; r.code = 6'd3; end
        else if (word_is(b, len, "int", 3))      begin r.kind = KIND_TYPE; r.code = 6'd4; end
        else if (word_is(b, len, "char", 4))     begin r.kind = KIND_TYPE; r.code = 6'd5; end
        else if (word_is(b, len, "double", 6))   begin r.kind = KIND_TYPE; r.code = 6'd6; end
        else if (word_is(b, len, "long", 4))     begin r.kind = KIND_TYPE; r.code = 6'd7; end
        else if (word_is(b, len, "float", 5))    begin r.kind = KIND_TYPE; r.code = 6'd8; end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/stsc_in_if.sv =====
// ----------------------------------------------------------------------------
// stsc_in_if
// source byte channel: valid, ready and one byte or end-of-file mark
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface stsc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       end_of_file;

    modport source (output valid, char_code, end_of_file, input ready);
    modport sink   (input valid, char_code, end_of_file, output ready);
endinterface

`default_nettype wire

// ===== rtl/stsc_out_if.sv =====
// ----------------------------------------------------------------------------
// stsc_out_if
// token record channel: valid, ready and one result record
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface stsc_out_if;
    logic        valid;
    logic        ready;
    logic [3:0]  kind;
    logic [5:0]  code;
    logic [7:0]  text_byte;
    logic [63:0] number_value;
    logic [15:0] token_row;
    logic [15:0] token_col;
    logic [1:0]  error_code;
    logic        last;

    modport source (output valid, kind, code, text_byte, number_value, token_row,
                    token_col, error_code, last, input ready);
    modport sink   (input valid, kind, code, text_byte, number_value, token_row,
                    token_col, error_code, last, output ready);
endinterface

`default_nettype wire

// ===== rtl/source_token_scanner.sv =====
// ----------------------------------------------------------------------------
// source_token_scanner
// streaming lexer: source bytes in, token and text records out
// ----------------------------------------------------------------------------
// One source byte, or an end-of-file mark, is taken per cycle whenever the
// record queue has room; the front decides the byte in that single cycle and
// writes the one or two records it causes, if any, into a two-entry queue.
// The back side drains one record per cycle while the output is ready, so
// the two records of one byte leave one after the other, and sustained
// input rate is one item per cycle as long as items average no more than
// one record each and the output does not stall.
`timescale 1ns / 1ps
`default_nettype none

module source_token_scanner #(
    parameter int POS_BITS   = stsc_pkg::POS_BITS_DEF,
    parameter int BRACE_BITS = stsc_pkg::BRACE_BITS_DEF
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    stsc_in_if.sink      i_in,
    stsc_out_if.source   o_out
);

    logic             push, space;
    stsc_pkg::t_entry entry;
    stsc_pkg::t_rec   rec;
    logic             last;

    // front: mode tracking and record forming
    stsc_front #(
        .POS_BITS   (POS_BITS),
        .BRACE_BITS (BRACE_BITS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_in.valid),
        .o_ready       (i_in.ready),
        .i_char_code   (i_in.char_code),
        .i_end_of_file (i_in.end_of_file),
        .i_space       (space),
        .o_push        (push),
        .o_entry       (entry)
    );

    // back: queue and record output
    stsc_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (entry),
        .o_space (space),
        .o_valid (o_out.valid),
        .i_ready (o_out.ready),
        .o_rec   (rec),
        .o_last  (last)
    );

    assign o_out.kind         = rec.kind;
    assign o_out.code         = rec.code;
    assign o_out.text_byte    = (rec.kind == stsc_pkg::KIND_TEXT) ? rec.text_byte : 8'd0;
    assign o_out.number_value = rec.number_value;
    assign o_out.token_row    = rec.token_row;
    assign o_out.token_col    = rec.token_col;
    assign o_out.error_code   = rec.error_code;
    assign o_out.last         = last;

endmodule

`default_nettype wire

// ===== rtl/stsc_front.sv =====
// ----------------------------------------------------------------------------
// stsc_front
// scanner front: takes one byte per cycle while the queue has room,
// updates lexer mode and position, and forms the one or two records it causes
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "source_token_scanner_defines.svh"

module stsc_front #(
    parameter int POS_BITS   = stsc_pkg::POS_BITS_DEF,
    parameter int BRACE_BITS = stsc_pkg::BRACE_BITS_DEF
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    output logic                 o_ready,
    input  wire logic [7:0]      i_char_code,
    input  wire logic            i_end_of_file,
    input  wire logic            i_space,
    output logic                 o_push,
    output stsc_pkg::t_entry     o_entry
);

    typedef enum logic [10:0] {
        MODE_IDLE   = 11'b000_0000_0001,
        MODE_NUM    = 11'b000_0000_0010,
        MODE_WORD   = 11'b000_0000_0100,
        MODE_STR    = 11'b000_0000_1000,
        MODE_OPER   = 11'b000_0001_0000,
        MODE_LINE   = 11'b000_0010_0000,
        MODE_BLOCK  = 11'b000_0100_0000,
        MODE_NWAIT  = 11'b000_1000_0000,
        MODE_NBRACE = 11'b001_0000_0000,
        MODE_NSEMI  = 11'b010_0000_0000,
        MODE_ERR    = 11'b100_0000_0000
    } t_mode;

    t_mode                 r_mode, n_mode;
    logic [63:0]           r_buf, n_buf;
    logic [3:0]            r_len, n_len;
    logic [63:0]           r_acc, n_acc;
    logic [5:0]            r_op, n_op;
    logic [7:0]            r_prev, n_prev;
    logic [BRACE_BITS-1:0] r_depth, n_depth;
    logic [POS_BITS-1:0]   r_cur_row, n_cur_row, r_cur_col, n_cur_col;
    logic [POS_BITS-1:0]   r_st_row, n_st_row, r_st_col, n_st_col;

    logic                  acc;
    logic [7:0]            c;
    logic [POS_BITS+15:0]  cr_x, cc_x, sr_x, sc_x;
    logic [15:0]           cr16, cc16, sr16, sc16;
    logic                  a_v, b_v, do_idle, do_nwait;
    stsc_pkg::t_rec        a_rec, b_rec;
    stsc_pkg::t_op_res     op_ext, op_one;
    stsc_pkg::t_word_cls   wcls;
    logic                  is_native;

    assign o_ready = i_space;
    assign acc     = i_valid && i_space;
    assign c       = i_char_code;

    // positions as output in their low 16 bits
    assign cr_x = {16'b0, r_cur_row};
    assign cc_x = {16'b0, r_cur_col};
    assign sr_x = {16'b0, r_st_row};
    assign sc_x = {16'b0, r_st_col};
    assign cr16 = cr_x[15:0];
    assign cc16 = cc_x[15:0];
    assign sr16 = sr_x[15:0];
    assign sc16 = sc_x[15:0];

    assign op_ext    = stsc_pkg::op_extend(r_op, c);
    assign op_one    = stsc_pkg::op_single(c);
    assign wcls      = stsc_pkg::word_class(r_buf, r_len);
    assign is_native = stsc_pkg::word_is(r_buf, r_len, "native", 6);

    // next state and records of one item
    always_comb begin
        n_mode = r_mode; n_buf = r_buf; n_len = r_len; n_acc = r_acc; n_op = r_op;
        n_prev = r_prev; n_depth = r_depth;
        n_cur_row = r_cur_row; n_cur_col = r_cur_col;
        n_st_row = r_st_row; n_st_col = r_st_col;
        a_v = 1'b0; b_v = 1'b0; do_idle = 1'b0; do_nwait = 1'b0;
        a_rec = stsc_pkg::mk_rec(stsc_pkg::KIND_TEXT, 6'd0, c, 64'd0, sr16, sc16,
                                 stsc_pkg::ERR_NONE);
        b_rec = a_rec;

        if (i_end_of_file) begin
            // flush pending token, then end record, then back to reset
            case (r_mode)
                MODE_NUM: begin
                    a_v = 1'b1;
                    a_rec = stsc_pkg::mk_rec(stsc_pkg::KIND_CONST, 6'd0, 8'd0, r_acc,
                                             sr16, sc16, stsc_pkg::ERR_NONE);
                end
                MODE_WORD: begin
                    a_v = 1'b1;
                    if (is_native)
                        a_rec = stsc_pkg::mk_rec(stsc_pkg::KIND_NATIVE, stsc_pkg::CODE_NATIVE,
                                                 8'd0, 64'd0, sr16, sc16, stsc_pkg::ERR_NONE);
                    else
                        a_rec = stsc_pkg::mk_rec(wcls.kind, wcls.code, 8'd0, 64'd0,
                                                 sr16, sc16, stsc_pkg::ERR_NONE);
                end
                MODE_STR: begin
                    a_v = 1'b1;
                    a_rec = stsc_pkg::mk_rec(stsc_pkg::KIND_ERROR, 6'd0, 8'd0, 64'd0,
                                             sr16, sc16, stsc_pkg::ERR_STRING);
                end
                MODE_OPER: begin
                    a_v = (r_op != stsc_pkg::OP_LINE_CMT) && (r_op != stsc_pkg::OP_BLOCK_CMT);
                    a_rec = stsc_pkg::mk_rec(stsc_pkg::KIND_OPER, r_op, 8'd0, 64'd0,
                                             sr16, sc16, stsc_pkg::ERR_NONE);
                end
                MODE_NWAIT, MODE_NBRACE, MODE_NSEMI: begin
                    a_v = 1'b1;
                    a_rec = stsc_pkg::mk_rec(stsc_pkg::KIND_NATIVE, stsc_pkg::CODE_NATIVE,
                                             8'd0, 64'd0, sr16, sc16, stsc_pkg::ERR_NONE);
                end
                default: a_v = 1'b0;
            endcase
            b_v = 1'b1;
            b_rec = stsc_pkg::mk_rec(stsc_pkg::KIND_END, 6'd0, 8'd0, 64'd0, cr16, cc16,
                                     stsc_pkg::ERR_NONE);
            n_mode = MODE_IDLE; n_buf = '0; n_len = '0; n_acc = '0; n_op = '0;
            n_prev = '0; n_depth = '0;
            n_cur_row = '0; n_cur_col = '0; n_st_row = '0; n_st_col = '0;
        end else begin
            case (r_mode)
                MODE_IDLE: do_idle = 1'b1;
                MODE_NUM: begin
                    if (stsc_pkg::is_dig(c)) begin
                        n_acc = (r_acc << 3) + (r_acc << 1) + {56'd0, c - stsc_pkg::CH_ZERO};
                    end else if (stsc_pkg::is_alf(c) || c == "_") begin
                        n_mode = MODE_ERR; a_v = 1'b1;
                        a_rec = stsc_pkg::mk_rec(stsc_pkg::KIND_ERROR, 6'd0, 8'd0, 64'd0,
                                                 sr16, sc16, stsc_pkg::ERR_LETTER);
                    end else begin
                        a_v = 1'b1; do_idle = 1'b1;
                        a_rec = stsc_pkg::mk_rec(stsc_pkg::KIND_CONST, 6'd0, 8'd0, r_acc,
                                                 sr16, sc16, stsc_pkg::ERR_NONE);
                    end
                end
                MODE_WORD: begin
                    a_v = 1'b1;
                    if (stsc_pkg::is_alf(c) || stsc_pkg::is_dig(c) || c == "_") begin
                        if (!r_len[3]) n_buf[{r_len[2:0], 3'b000} +: 8] = c;
                        if (r_len != 4'd9) n_len = r_len + 4'd1;
                    end else if (is_native) begin
                        do_nwait = 1'b1;
                        a_rec = stsc_pkg::mk_rec(stsc_pkg::KIND_NSTART, stsc_pkg::CODE_NATIVE,
                                                 8'd0, 64'd0, sr16, sc16, stsc_pkg::ERR_NONE);
                    end else begin
                        do_idle = 1'b1;
                        a_rec = stsc_pkg::mk_rec(wcls.kind, wcls.code, 8'd0, 64'd0,
                                                 sr16, sc16, stsc_pkg::ERR_NONE);
                    end
                end
                MODE_STR: begin
                    a_v = 1'b1;
                    if (c == stsc_pkg::CH_QUOTE && r_prev != stsc_pkg::CH_BSLASH) begin
                        n_mode = MODE_IDLE;
                        a_rec = stsc_pkg::mk_rec(stsc_pkg::KIND_STRING, 6'd0, 8'd0, 64'd0,
                                                 sr16, sc16, stsc_pkg::ERR_NONE);
                    end else begin
                        n_prev = c;
                    end
                end
                MODE_OPER: begin
                    if (op_ext.hit && c != 8'd0) begin
                        n_op = op_ext.idx;
                    end else if (r_op == stsc_pkg::OP_LINE_CMT) begin
                        n_mode = (c == stsc_pkg::CH_NL) ? MODE_IDLE : MODE_LINE;
                    end else if (r_op == stsc_pkg::OP_BLOCK_CMT) begin
                        n_mode = MODE_BLOCK; n_prev = c;
                    end else begin
                        a_v = 1'b1; do_idle = 1'b1;
                        a_rec = stsc_pkg::mk_rec(stsc_pkg::KIND_OPER, r_op, 8'd0, 64'd0,
                                                 sr16, sc16, stsc_pkg::ERR_NONE);
                    end
                end
                MODE_LINE: if (c == stsc_pkg::CH_NL) n_mode = MODE_IDLE;
                MODE_BLOCK: begin
                    if (r_prev == stsc_pkg::CH_STAR && c == stsc_pkg::CH_SLASH)
                        n_mode = MODE_IDLE;
                    else
                        n_prev = c;
                end
                MODE_NWAIT: do_nwait = 1'b1;
                MODE_NBRACE: begin
                    a_v = 1'b1;
                    if (c == 8'd0) begin
                        n_mode = MODE_IDLE;
                        a_rec = stsc_pkg::mk_rec(stsc_pkg::KIND_NATIVE, stsc_pkg::CODE_NATIVE,
                                                 8'd0, 64'd0, sr16, sc16, stsc_pkg::ERR_NONE);
                    end else if (c == stsc_pkg::CH_LBRACE) begin
                        if (r_depth != '1) n_depth = r_depth + 1'b1;
                    end else if (c == stsc_pkg::CH_RBRACE) begin
                        if (r_depth != '0) n_depth = r_depth - 1'b1;
                        if (n_depth == '0) begin
                            n_mode = MODE_IDLE;
                            a_rec = stsc_pkg::mk_rec(stsc_pkg::KIND_NATIVE,
                                                     stsc_pkg::CODE_NATIVE, 8'd0, 64'd0,
                                                     sr16, sc16, stsc_pkg::ERR_NONE);
                        end
                    end
                end
                MODE_NSEMI: begin
                    a_v = 1'b1;
                    if (c == stsc_pkg::CH_SEMI) begin
                        n_mode = MODE_IDLE;
                        a_rec = stsc_pkg::mk_rec(stsc_pkg::KIND_NATIVE, stsc_pkg::CODE_NATIVE,
                                                 8'd0, 64'd0, sr16, sc16, stsc_pkg::ERR_NONE);
                    end
                end
                MODE_ERR: a_v = 1'b0;
                default: do_idle = 1'b1;
            endcase

            // byte seen with no token open
            if (do_idle) begin
                n_mode = MODE_IDLE;
                if (!stsc_pkg::is_sp(c)) begin
                    n_st_row = r_cur_row; n_st_col = r_cur_col;
                    if (stsc_pkg::is_dig(c)) begin
                        n_mode = MODE_NUM; n_acc = {56'd0, c - stsc_pkg::CH_ZERO};
                    end else if (stsc_pkg::is_alf(c) || c == "_") begin
                        n_mode = MODE_WORD; n_buf = {56'd0, c}; n_len = 4'd1;
                        b_v = 1'b1;
                        b_rec = stsc_pkg::mk_rec(stsc_pkg::KIND_TEXT, 6'd0, c, 64'd0,
                                                 cr16, cc16, stsc_pkg::ERR_NONE);
                    end else if (c == stsc_pkg::CH_QUOTE) begin
                        n_mode = MODE_STR; n_prev = 8'd0;
                    end else if (op_one.hit) begin
                        n_mode = MODE_OPER; n_op = op_one.idx;
                    end else begin
                        n_mode = MODE_ERR; b_v = 1'b1;
                        b_rec = stsc_pkg::mk_rec(stsc_pkg::KIND_ERROR, 6'd0, 8'd0, 64'd0,
                                                 cr16, cc16, stsc_pkg::ERR_UNKNOWN);
                    end
                end
            end

            // byte after the native keyword
            if (do_nwait) begin
                n_mode = MODE_NWAIT;
                if (!stsc_pkg::is_sp(c)) begin
                    if (c == stsc_pkg::CH_LBRACE) begin
                        n_mode = MODE_NBRACE; n_depth = BRACE_BITS'(1);
                    end else begin
                        n_mode = MODE_NSEMI; b_v = 1'b1;
                    end
                end
            end

            // position of the next byte
            if (c == stsc_pkg::CH_NL) begin
                if (r_cur_row != '1) n_cur_row = r_cur_row + 1'b1;
                n_cur_col = '0;
            end else if (r_cur_col != '1) begin
                n_cur_col = r_cur_col + 1'b1;
            end
        end
    end

    // compact the records of this item into one entry
    always_comb begin
        o_push        = acc && (a_v || b_v);
        o_entry.two   = a_v && b_v;
        o_entry.rec0  = a_v ? a_rec : b_rec;
        o_entry.rec1  = b_rec;
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_IDLE; r_buf <= '0; r_len <= '0; r_acc <= '0; r_op <= '0;
            r_prev <= '0; r_depth <= '0;
            r_cur_row <= '0; r_cur_col <= '0; r_st_row <= '0; r_st_col <= '0;
        end else if (acc) begin
            r_mode <= n_mode; r_buf <= n_buf; r_len <= n_len; r_acc <= n_acc; r_op <= n_op;
            r_prev <= n_prev; r_depth <= n_depth;
            r_cur_row <= n_cur_row; r_cur_col <= n_cur_col;
            r_st_row <= n_st_row; r_st_col <= n_st_col;
        end
    end

    `STSC_ASSERT_NEXT(a_eof_resets, i_clk, i_rst_n, acc && i_end_of_file, r_mode == MODE_IDLE && r_cur_row == '0 && r_cur_col == '0)
    `STSC_ASSERT_NOW(a_brace_open, i_clk, i_rst_n, r_mode == MODE_NBRACE, r_depth != '0)
    `STSC_ASSERT_NOW(a_eof_pushes, i_clk, i_rst_n, acc && i_end_of_file, o_push && o_entry.rec1.kind == stsc_pkg::KIND_END)

endmodule

`default_nettype wire

// ===== rtl/stsc_back.sv =====
// ----------------------------------------------------------------------------
// stsc_back
// two-entry record queue and output sequencer: hands out the records of
// each entry in order and marks the final one of an item
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "source_token_scanner_defines.svh"

module stsc_back (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire stsc_pkg::t_entry i_entry,
    output logic                  o_space,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output stsc_pkg::t_rec        o_rec,
    output logic                  o_last
);

    stsc_pkg::t_entry r_q [2];
    logic             r_wp, r_rp, r_sub;
    logic [1:0]       r_count;
    logic             pop, take;
    stsc_pkg::t_entry head;

    assign head    = r_q[r_rp];
    assign o_valid = r_count != 2'd0;
    assign o_last  = !head.two || r_sub;
    assign o_rec   = r_sub ? head.rec1 : head.rec0;
    assign take    = o_valid && i_ready;
    assign pop     = take && o_last;
    // a slot frees in the same cycle the head leaves
    assign o_space = (r_count != 2'd2) || pop;

    // queue storage
    always_ff @(posedge i_clk) begin
        if (i_push) r_q[r_wp] <= i_entry;
    end

    // pointers, fill count and record select
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_sub <= 1'b0; r_count <= 2'd0;
        end else begin
            if (i_push) r_wp <= !r_wp;
            if (pop) r_rp <= !r_rp;
            if (take) r_sub <= !o_last;
            if (i_push && !pop) r_count <= r_count + 2'd1;
            else if (pop && !i_push) r_count <= r_count - 2'd1;
        end
    end

    `STSC_ASSERT_NOW(a_count_max, i_clk, i_rst_n, 1'b1, r_count != 2'd3)
    `STSC_ASSERT_NOW(a_sub_two, i_clk, i_rst_n, r_sub, o_valid && head.two)
    `STSC_ASSERT_NEXT(a_pop_only, i_clk, i_rst_n, pop && !i_push, r_count == $past(r_count) - 2'd1)

endmodule

`default_nettype wire
